// ===== hdl/irfs_pkg.sv =====
// Shared types, codes and constants of the infrared remote frame sender.
// Holds the key-to-code table, the configuration record and the result record.
// No dependencies.
package irfs_pkg;

	localparam int KEY_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;
	localparam int BIT_CNT_W  = 6;

	// Key codes with a meaning of their own
	localparam logic [KEY_W-1:0] KEY_NONE     = 5'd0;
	localparam logic [KEY_W-1:0] KEY_POWER    = 5'd1;
	localparam logic [KEY_W-1:0] KEY_SELECT   = 5'd5;
	localparam logic [KEY_W-1:0] KEY_VOL_UP   = 5'd11;
	localparam logic [KEY_W-1:0] KEY_VOL_DOWN = 5'd13;
	localparam logic [KEY_W-1:0] KEY_OK       = 5'd15;
	localparam logic [KEY_W-1:0] KEY_MIN      = 5'd1;
	localparam logic [KEY_W-1:0] KEY_MAX      = 5'd24;

	// Bits in one frame and long waits after the power frame, less one
	localparam logic [BIT_CNT_W-1:0] FRAME_BITS      = 6'd32;
	localparam logic [3:0]           POWER_ON_WAITS  = 4'd10;
	localparam logic [3:0]           POWER_OFF_WAITS = 4'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME_VOLUME     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS       = 3'd5;

	localparam logic [7:0] VOLUME_RESET = 8'd10;

	typedef struct packed {
		logic [15:0] device_address;
		logic [7:0]  volume_limit;
		logic [7:0]  home_volume;
		logic [15:0] unit_ticks;
		logic [31:0] long_wait_ticks;
		logic [31:0] gap_ticks;
	} irfs_cfg_t;

	localparam irfs_cfg_t CFG_RESET = '{
		device_address:  16'h40BE,
		volume_limit:    8'd80,
		home_volume:     8'd10,
		unit_ticks:      16'd2813,
		long_wait_ticks: 32'd5000000,
		gap_ticks:       32'd1000000
	};

	// Queue commands from the engine
	typedef struct packed {
		logic             push;
		logic             pop;
		logic             clear;
		logic [KEY_W-1:0] key;
	} irfs_qctrl_t;

	// Queue status towards the engine
	typedef struct packed {
		logic             nonempty;
		logic             full;
		logic [KEY_W-1:0] head;
	} irfs_qstat_t;

	// Result item, packed lowest field in the lowest bit
	typedef struct packed {
		logic       power_state;
		logic [7:0] volume_level;
		logic       accepted;
		logic       busy_res;
		logic       carrier_on;
	} irfs_result_t;

	// Lower 16 bits of the frame for each key
	function automatic logic [15:0] irfs_key_word(input logic [KEY_W-1:0] key);
		logic [15:0] w;
		unique case (key)
			5'd1:    w = 16'h629D;
			5'd2:    w = 16'h32CD;
			5'd3:    w = 16'hA25D;
			5'd4:    w = 16'hD22D;
			5'd5:    w = 16'h52AD;
			5'd6:    w = 16'h12ED;
			5'd7:    w = 16'h728D;
			5'd8:    w = 16'h926D;
			5'd9:    w = 16'hB24D;
			5'd10:   w = 16'hB04F;
			5'd11:   w = 16'hF00F;
			5'd12:   w = 16'h30CF;
			5'd13:   w = 16'h5AA5;
			5'd14:   w = 16'h9867;
			5'd15:   w = 16'h807F;
			5'd16:   w = 16'h40BF;
			5'd17:   w = 16'hC03F;
			5'd18:   w = 16'h20DF;
			5'd19:   w = 16'hA05F;
			5'd20:   w = 16'h609F;
			5'd21:   w = 16'hE01F;
			5'd22:   w = 16'h10EF;
			5'd23:   w = 16'h906F;
			5'd24:   w = 16'h00FF;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/ir_remote_frame_sender_core.sv =====
// NEC infrared remote transmitter: key queue, frame engine and power macros.
// Instantiates irfs_cfg_regs, irfs_key_queue, irfs_frame_engine, irfs_out_buf.
//
// One input transfer is either a timer tick (s_tuser = 0) or a key request
// (s_tuser = 1, key 1 to 24 in s_tdata). Every transfer is processed in the
// cycle it is accepted and yields exactly one result transfer, registered
// and presented on m_tdata, or held in the skid stage while m_tready is low.
// Throughput is one item per clock until the skid stage fills: the frame
// engine updates its whole state per item, and s_tready stays high while
// one result waits on the output. There is no clearing pass after reset.
// Configuration writes are always taken (cfg_ready is tied high) and should
// only be issued while no frame, wait or macro is running.
module ir_remote_frame_sender_core #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [irfs_pkg::IN_DATA_W-1:0]      s_tdata,   // [4:0] key_code
	input  logic                                s_tuser,   // [0] cmd
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] carrier_on, [1] busy_res, [2] accepted, [10:3] volume_level,
	// [11] power_state
	output logic [irfs_pkg::OUT_DATA_W-1:0]     m_tdata,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [irfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int RES_W = $bits(irfs_pkg::irfs_result_t);

	irfs_pkg::irfs_cfg_t    cfg;
	irfs_pkg::irfs_qctrl_t  qctrl;
	irfs_pkg::irfs_qstat_t  qstat;
	irfs_pkg::irfs_result_t result, out_res;
	logic                   accept;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	irfs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	irfs_key_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.stat   (qstat)
	);

	irfs_frame_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (s_tuser),
		.key_code (s_tdata[irfs_pkg::KEY_W-1:0]),
		.cfg      (cfg),
		.qstat    (qstat),
		.qctrl    (qctrl),
		.result   (result)
	);

	irfs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_data   (result),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// Pad the result record to whole bytes
	assign m_tdata = {{(irfs_pkg::OUT_DATA_W - RES_W){1'b0}}, out_res};

endmodule

// ===== hdl/irfs_cfg_regs.sv =====
// Configuration register bank of the infrared remote frame sender.
// Decodes register writes into the configuration record; uses irfs_pkg.
module irfs_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [irfs_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [irfs_pkg::CFG_DATA_W-1:0]     wr_data,
	output irfs_pkg::irfs_cfg_t                 cfg
);

	irfs_pkg::irfs_cfg_t cfg_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= irfs_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				irfs_pkg::CFG_DEVICE_ADDRESS:  cfg_q.device_address  <= wr_data[15:0];
				irfs_pkg::CFG_VOLUME_LIMIT:    cfg_q.volume_limit    <= wr_data[7:0];
				irfs_pkg::CFG_HOME_VOLUME:     cfg_q.home_volume     <= wr_data[7:0];
				irfs_pkg::CFG_UNIT_TICKS:      cfg_q.unit_ticks      <= wr_data[15:0];
				irfs_pkg::CFG_LONG_WAIT_TICKS: cfg_q.long_wait_ticks <= wr_data;
				irfs_pkg::CFG_GAP_TICKS:       cfg_q.gap_ticks       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/irfs_key_queue.sv =====
// Key request queue of the infrared remote frame sender: a shift line with
// a fill count, head at entry 0. Uses irfs_pkg.
module irfs_key_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  irfs_pkg::irfs_qctrl_t ctrl,
	output irfs_pkg::irfs_qstat_t stat
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [irfs_pkg::KEY_W-1:0] entry_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]           count_q;

	// Track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop && count_q != '0) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Shift towards the head on pop, write the tail slot on push
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (ctrl.pop) begin
				if (g < QUEUE_DEPTH - 1) begin
					entry_q[g] <= entry_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
				end
			end else if (ctrl.push && count_q == CNT_W'(g)) begin
				entry_q[g] <= ctrl.key;
			end
		end
	end

	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.head     = entry_q[0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("key queue fill count beyond depth");

	a_push_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !ctrl.pop && !ctrl.clear && !stat.full)
		else $error("key queue push together with pop, clear or when full");

endmodule

// ===== hdl/irfs_frame_engine.sv =====
// Frame engine of the infrared remote frame sender: segment timing, bit
// shifting, volume tracking and power macros, one item per cycle.
// Uses irfs_pkg; drives the key queue through irfs_qctrl_t.
module irfs_frame_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            cmd,
	input  logic [irfs_pkg::KEY_W-1:0]      key_code,
	input  irfs_pkg::irfs_cfg_t             cfg,
	input  irfs_pkg::irfs_qstat_t           qstat,
	output irfs_pkg::irfs_qctrl_t           qctrl,
	output irfs_pkg::irfs_result_t          result
);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEADER = 3'd1,
		PH_LSPACE = 3'd2,
		PH_BMARK  = 3'd3,
		PH_BSPACE = 3'd4,
		PH_STOP   = 3'd5,
		PH_LWAIT  = 3'd6,
		PH_GAP    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		MAC_NONE    = 3'd0,
		MAC_POWER   = 3'd1,
		MAC_VOLUME  = 3'd2,
		MAC_CONFIRM = 3'd3,
		MAC_SELECT  = 3'd4
	} mac_t;

	phase_t                         phase_q, phase_d;
	mac_t                           mac_q, mac_d, mac_cur;
	logic [31:0]                    tick_q, tick_d, tick_inc, seg_len;
	logic [irfs_pkg::BIT_CNT_W-1:0] bit_q, bit_d, bit_inc;
	logic [31:0]                    shift_q, shift_d;
	logic [7:0]                     vol_q, vol_d;
	logic                           power_q, power_d;
	logic [3:0]                     wait_q, wait_d;
	logic                           acc, start, send, run_macro;
	logic [irfs_pkg::KEY_W-1:0]     start_key;

	// Length of the current segment in ticks
	always_comb begin
		unique case (phase_q)
			PH_LEADER: seg_len = {12'b0, cfg.unit_ticks, 4'b0};
			PH_LSPACE: seg_len = {13'b0, cfg.unit_ticks, 3'b0};
			PH_BSPACE: seg_len = shift_q[31] ?
				({16'b0, cfg.unit_ticks} + {15'b0, cfg.unit_ticks, 1'b0}) :
				{16'b0, cfg.unit_ticks};
			PH_LWAIT:  seg_len = cfg.long_wait_ticks;
			PH_GAP:    seg_len = cfg.gap_ticks;
			default:   seg_len = {16'b0, cfg.unit_ticks};
		endcase
	end

	assign tick_inc = tick_q + 32'd1;
	assign bit_inc  = bit_q + irfs_pkg::BIT_CNT_W'(1);

	// Next state for one accepted item
	always_comb begin
		phase_d   = phase_q;
		mac_d     = mac_q;
		mac_cur   = mac_q;
		tick_d    = tick_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		vol_d     = vol_q;
		power_d   = power_q;
		wait_d    = wait_q;
		qctrl     = '0;
		qctrl.key = key_code;
		acc       = 1'b0;
		start     = 1'b0;
		send      = 1'b1;
		run_macro = 1'b0;
		start_key = irfs_pkg::KEY_NONE;

		if (accept) begin
			if (cmd) begin
				// Enqueue a valid key unless a macro runs or the queue is full
				if (key_code >= irfs_pkg::KEY_MIN && key_code <= irfs_pkg::KEY_MAX &&
				    mac_q == MAC_NONE && !qstat.full) begin
					qctrl.push = 1'b1;
					acc        = 1'b1;
				end
			end else if (phase_q == PH_IDLE) begin
				// Dispatch the oldest key
				if (qstat.nonempty) begin
					if (qstat.head == irfs_pkg::KEY_POWER) begin
						if (!power_q) begin
							mac_d     = MAC_POWER;
							power_d   = 1'b1;
							wait_d    = irfs_pkg::POWER_ON_WAITS;
							qctrl.pop = 1'b1;
							start     = 1'b1;
							start_key = irfs_pkg::KEY_POWER;
						end else begin
							qctrl.clear = 1'b1;
							run_macro   = 1'b1;
							mac_cur     = MAC_VOLUME;
						end
					end else begin
						if (power_q && qstat.head == irfs_pkg::KEY_VOL_UP) begin
							if (vol_q < cfg.volume_limit) begin
								vol_d = vol_q + 8'd1;
							end else begin
								send = 1'b0;
							end
						end else if (power_q && qstat.head == irfs_pkg::KEY_VOL_DOWN) begin
							if (vol_q != 8'd0) begin
								vol_d = vol_q - 8'd1;
							end else begin
								send = 1'b0;
							end
						end
						qctrl.pop = 1'b1;
						start     = send;
						start_key = qstat.head;
					end
				end
			end else if (tick_inc >= seg_len) begin
				// End of segment: advance the phase, count down a long wait or run the next macro step
				tick_d = '0;
				unique case (phase_q)
					PH_IDLE: ;
					PH_LEADER: phase_d = PH_LSPACE;
					PH_LSPACE: begin
						phase_d = PH_BMARK;
						bit_d   = '0;
					end
					PH_BMARK: phase_d = PH_BSPACE;
					PH_BSPACE: begin
						shift_d = {shift_q[30:0], 1'b0};
						bit_d   = bit_inc;
						phase_d = (bit_inc >= irfs_pkg::FRAME_BITS) ? PH_STOP : PH_BMARK;
					end
					PH_STOP: begin
						bit_d = '0;
						if (mac_q == MAC_NONE) begin
							phase_d = PH_IDLE;
						end else if (mac_q == MAC_POWER) begin
							phase_d = PH_LWAIT;
						end else begin
							phase_d = PH_GAP;
						end
					end
					PH_LWAIT: begin
						if (wait_q != 4'd0) begin
							wait_d = wait_q - 4'd1;
						end else begin
							mac_d   = MAC_NONE;
							phase_d = PH_IDLE;
						end
					end
					PH_GAP: run_macro = 1'b1;
				endcase
			end else begin
				tick_d = tick_inc;
			end
		end

		// Power-off macro: step the volume home, then OK, select, power
		if (run_macro) begin
			mac_d = mac_cur;
			start = 1'b1;
			if (mac_cur == MAC_VOLUME) begin
				if (vol_q < cfg.home_volume) begin
					vol_d     = vol_q + 8'd1;
					start_key = irfs_pkg::KEY_VOL_UP;
				end else if (vol_q > cfg.home_volume) begin
					vol_d     = vol_q - 8'd1;
					start_key = irfs_pkg::KEY_VOL_DOWN;
				end else begin
					mac_d     = MAC_CONFIRM;
					start_key = irfs_pkg::KEY_OK;
				end
			end else if (mac_cur == MAC_CONFIRM) begin
				mac_d     = MAC_SELECT;
				start_key = irfs_pkg::KEY_SELECT;
			end else begin
				mac_d     = MAC_POWER;
				power_d   = 1'b0;
				wait_d    = irfs_pkg::POWER_OFF_WAITS;
				start_key = irfs_pkg::KEY_POWER;
			end
		end

		// Load a fresh frame: address high, key word low
		if (start) begin
			shift_d = {cfg.device_address, irfs_pkg::irfs_key_word(start_key)};
			bit_d   = '0;
			tick_d  = '0;
			phase_d = PH_LEADER;
		end
	end

	// Hold the engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mac_q   <= MAC_NONE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			vol_q   <= irfs_pkg::VOLUME_RESET;
			power_q <= 1'b0;
			wait_q  <= '0;
		end else begin
			phase_q <= phase_d;
			mac_q   <= mac_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			vol_q   <= vol_d;
			power_q <= power_d;
			wait_q  <= wait_d;
		end
	end

	// Result seen after this item
	assign result.carrier_on   = (phase_d == PH_LEADER) || (phase_d == PH_BMARK) ||
	                             (phase_d == PH_STOP);
	assign result.busy_res     = (phase_d != PH_IDLE);
	assign result.accepted     = acc;
	assign result.volume_level = vol_d;
	assign result.power_state  = power_d;

	a_idle_no_macro: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (mac_q == MAC_NONE))
		else $error("engine idle with a macro still active");

	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= irfs_pkg::FRAME_BITS)
		else $error("bit counter past end of frame");

	a_power_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(power_q) |-> (mac_q == MAC_POWER) && (phase_q == PH_LEADER))
		else $error("power state changed outside a power frame start");

endmodule

// ===== hdl/irfs_out_buf.sv =====
// Two-deep result buffer of the infrared remote frame sender: an output
// register with a skid stage behind it. Uses irfs_pkg.
module irfs_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  irfs_pkg::irfs_result_t in_data,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output irfs_pkg::irfs_result_t out_data
);

	logic                   main_v_q, skid_v_q;
	irfs_pkg::irfs_result_t main_q, skid_q;

	// Advance valid flags: refill the output from skid first, else from input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// Move payload alongside the flags
	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (in_valid) begin
				main_q <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid stage holds a result while output register is empty");

endmodule
